FILE: hw/rtl/text_console_line_editor_core_assert.svh
// Assertion macros for the text console line editor RTL, included by the back end.
`ifndef TEXT_CONSOLE_LINE_EDITOR_CORE_ASSERT_SVH
`define TEXT_CONSOLE_LINE_EDITOR_CORE_ASSERT_SVH

// The condition must never hold while out of reset.
`define TCLE_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// When pre holds, post must hold in the same cycle.
`define TCLE_ASSERT_IMPLY(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

`endif

FILE: hw/rtl/tcle_pkg.sv
// Package with types and constants of the text console line editor.
package tcle_pkg;

    localparam int COLUMNS      = 80;
    localparam int ROWS         = 25;
    localparam int LINE_DEPTH   = 63;
    localparam int READER_DEPTH = 15;
    localparam int CELLS        = COLUMNS * ROWS;

    localparam int CURSOR_W = 11;
    localparam int LINE_W   = 6;
    localparam int READER_W = 4;
    localparam int COL_W    = $clog2(COLUMNS);

    localparam logic [7:0] KEY_BACKSPACE = 8'h08;
    localparam logic [7:0] KEY_NEWLINE   = 8'h0A;
    localparam logic [7:0] KEY_ESCAPE    = 8'h1B;
    localparam logic [7:0] BLANK         = 8'h20;
    localparam logic [7:0] COLOR_RESET   = 8'h60;

    localparam logic [2:0] KIND_PRINT   = 3'd0;
    localparam logic [2:0] KIND_TYPED   = 3'd1;
    localparam logic [2:0] KIND_NEWLINE = 3'd2;
    localparam logic [2:0] KIND_CLEAR   = 3'd3;
    localparam logic [2:0] KIND_READ    = 3'd4;
    localparam logic [2:0] KIND_READER  = 3'd5;

    typedef struct packed {
        logic [2:0]          kind;
        logic [7:0]          character;
        logic [CURSOR_W-1:0] cell_index;
    } in_item_t;

    typedef struct packed {
        logic                result_kind;
        logic [CURSOR_W-1:0] cursor_position;
        logic [LINE_W-1:0]   line_length;
        logic [7:0]          cell_char;
        logic [7:0]          cell_color;
        logic [7:0]          line_char;
        logic                last;
        logic [READER_W-1:0] readers_pending;
    } out_item_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_PUT,
        OP_NEWROW,
        OP_NEWROW_IF,
        OP_BACKSPACE,
        OP_TYPE,
        OP_DELIVER,
        OP_ESCAPE,
        OP_CLEAR,
        OP_READ,
        OP_READER_REQ
    } op_t;

    typedef struct packed {
        op_t                 op;
        logic [7:0]          character;
        logic [CURSOR_W-1:0] cell_index;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_SWEEP,
        ST_DRAIN,
        ST_IDLE,
        ST_READ_WAIT,
        ST_STATUS,
        ST_LINE_RD,
        ST_LINE_EMIT,
        ST_TERM
    } back_state_t;

endpackage

FILE: hw/rtl/text_console_line_editor_core.sv
// Top level of the text console line editor.
//
// Text console line editor: an 80x25 character screen with a cursor, a
// keyboard edit line of up to 63 characters and a count of up to 15
// waiting readers. Each request gives one status result, except a typed
// newline while a reader waits, which gives the line characters and a
// zero terminator. A request is registered in the command queue and is
// taken from it by the back end while the back end is idle. Most requests
// then go to the status state, which loads the result register once the
// output slot is free; a cell read passes a read wait state first. A
// clear, an escape or a scroll walks the screen memory one cell a cycle
// through its single write port: the back end takes the request, walks
// every cell, finishes the last write in its drain state and gives the
// status. Each character of a delivered line passes a line read state and
// an emit state, and the terminator has a state of its own. After reset
// the screen memory is blanked by a clearing pass before the first request
// is carried out. Requests are still accepted into the four-entry command
// queue meanwhile. The configuration register screen_color is always
// ready. A cell read uses its value at the time the back end carries out
// the read, so write it only while no request is in flight.
module text_console_line_editor_core
    import tcle_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  in_item_t   in_item,
    output logic       out_valid,
    input  logic       out_ready,
    output out_item_t  out_item,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data
);

    logic [7:0] screen_color_reg;
    logic       q_push;
    logic       q_ready;
    cmd_t       q_cmd;
    cmd_t       pop_cmd;
    logic       pop_valid;
    logic       pop;

    // The color register takes every request in the cycle it arrives.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            screen_color_reg <= COLOR_RESET;
        else if (cfg_valid)
            screen_color_reg <= cfg_data;
    end

    // Front end classifies each request into a command for the back end.
    tcle_front u_front (
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_item  (in_item),
        .q_push   (q_push),
        .q_cmd    (q_cmd),
        .q_ready  (q_ready)
    );

    // The queue lets the front keep accepting while the back end sweeps.
    tcle_cmd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_cmd   (q_cmd),
        .push_ready (q_ready),
        .pop        (pop),
        .pop_cmd    (pop_cmd),
        .pop_valid  (pop_valid)
    );

    // The back end owns the screen and line memories and the result register.
    tcle_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (pop_cmd),
        .cmd_valid    (pop_valid),
        .cmd_pop      (pop),
        .screen_color (screen_color_reg),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_item     (out_item)
    );

endmodule

FILE: hw/rtl/tcle_front.sv
// Front end: accepts requests and classifies them into back end commands.
module tcle_front
    import tcle_pkg::*;
(
    input  logic     in_valid,
    output logic     in_ready,
    input  in_item_t in_item,
    output logic     q_push,
    output cmd_t     q_cmd,
    input  logic     q_ready
);

    op_t op;

    always_comb
    begin
        case (in_item.kind)
            KIND_PRINT:
            begin
                if (in_item.character == KEY_NEWLINE)
                    op = OP_NEWROW;
                else if (in_item.character == 8'd0)
                    op = OP_NOP;
                else
                    op = OP_PUT;
            end
            KIND_TYPED:
            begin
                if (in_item.character == KEY_BACKSPACE)
                    op = OP_BACKSPACE;
                else if (in_item.character == KEY_NEWLINE)
                    op = OP_DELIVER;
                else if (in_item.character == KEY_ESCAPE)
                    op = OP_ESCAPE;
                else
                    op = OP_TYPE;
            end
            KIND_NEWLINE: op = OP_NEWROW_IF;
            KIND_CLEAR:   op = OP_CLEAR;
            KIND_READ:    op = OP_READ;
            KIND_READER:  op = OP_READER_REQ;
            default:      op = OP_NOP;
        endcase
    end

    assign in_ready = q_ready;
    assign q_push   = in_valid & q_ready;
    assign q_cmd    = '{op: op, character: in_item.character, cell_index: in_item.cell_index};

endmodule

FILE: hw/rtl/tcle_cmd_queue.sv
// Four-entry command queue between the front and back ends.
module tcle_cmd_queue
    import tcle_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic push_ready,
    input  logic pop,
    output cmd_t pop_cmd,
    output logic pop_valid
);

    cmd_t       entry_reg [4];
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [2:0] count_reg, count_next;

    assign push_ready = (count_reg != 3'd4);
    assign pop_valid  = (count_reg != 3'd0);
    assign pop_cmd    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 2'd1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 2'd1 : rd_ptr_reg;
        count_next  = count_reg + {2'd0, push} - {2'd0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

FILE: hw/rtl/tcle_back.sv
// Back end: screen and line memories, cursor, sequencer and result register.
module tcle_back
    import tcle_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cmd_t       cmd,
    input  logic       cmd_valid,
    output logic       cmd_pop,
    input  logic [7:0] screen_color,
    output logic       out_valid,
    input  logic       out_ready,
    output out_item_t  out_item
);

`include "text_console_line_editor_core_assert.svh"

    localparam logic [CURSOR_W:0]   CELLS_X    = (CURSOR_W+1)'(CELLS);
    localparam logic [CURSOR_W:0]   COLUMNS_X  = (CURSOR_W+1)'(COLUMNS);
    localparam logic [CURSOR_W-1:0] LAST_CELL  = CURSOR_W'(CELLS - 1);
    localparam logic [CURSOR_W-1:0] LAST_ROW   = CURSOR_W'(CELLS - COLUMNS);
    localparam logic [COL_W-1:0]    LAST_COL   = COL_W'(COLUMNS - 1);
    localparam logic [LINE_W-1:0]   LINE_FULL  = LINE_W'(LINE_DEPTH);
    localparam logic [READER_W-1:0] READER_MAX = READER_W'(READER_DEPTH);

    logic [7:0] frame_mem [CELLS];
    logic [7:0] line_mem [LINE_DEPTH];

    back_state_t         state_reg, state_next;
    back_state_t         ret_reg, ret_next;
    logic [CURSOR_W-1:0] cursor_reg, cursor_next;
    logic [COL_W-1:0]    col_reg, col_next;
    logic [LINE_W-1:0]   lc_reg, lc_next;
    logic [READER_W-1:0] readers_reg, readers_next;
    logic [CURSOR_W-1:0] scan_reg, scan_next;
    logic                sweep_blank_reg, sweep_blank_next;
    logic                wr_pend_reg, wr_pend_next;
    logic [CURSOR_W-1:0] wr_addr_reg, wr_addr_next;
    logic                wr_use_rd_reg, wr_use_rd_next;
    logic [7:0]          wr_data_reg, wr_data_next;
    logic [CURSOR_W-1:0] rd_addr;
    logic [7:0]          rd_data_reg;
    logic                read_ok_reg, read_ok_next;
    logic [7:0]          cchar_reg, cchar_next;
    logic [7:0]          ccol_reg, ccol_next;
    logic [LINE_W-1:0]   n_reg, n_next;
    logic [LINE_W-1:0]   line_idx_reg, line_idx_next;
    logic [7:0]          line_rd_reg;
    logic                line_we;
    logic                out_valid_reg, out_valid_next;
    out_item_t           out_item_reg, out_item_next;

    logic                slot_free;
    logic [CURSOR_W:0]   cur_inc;
    logic                put_wrap;
    logic [CURSOR_W-1:0] put_cursor;
    logic [COL_W-1:0]    put_col;
    logic [CURSOR_W:0]   nr_sum;
    logic                nr_wrap;
    logic [CURSOR_W-1:0] nr_cursor;
    logic [CURSOR_W:0]   scan_ahead;

    assign slot_free  = !out_valid_reg || out_ready;
    assign cur_inc    = {1'b0, cursor_reg} + 1'b1;
    assign put_wrap   = (cur_inc == CELLS_X);
    assign put_cursor = put_wrap ? LAST_ROW : cur_inc[CURSOR_W-1:0];
    assign put_col    = (col_reg == LAST_COL) ? '0 : col_reg + 1'b1;
    assign nr_sum     = {1'b0, cursor_reg} - {{(CURSOR_W+1-COL_W){1'b0}}, col_reg} + COLUMNS_X;
    assign nr_wrap    = (nr_sum >= CELLS_X);
    assign nr_cursor  = nr_wrap ? CURSOR_W'(nr_sum - COLUMNS_X) : nr_sum[CURSOR_W-1:0];
    assign scan_ahead = {1'b0, scan_reg} + COLUMNS_X;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_SWEEP:
                if (scan_reg == LAST_CELL)
                    state_next = ST_DRAIN;
            ST_DRAIN:
                state_next = ret_reg;
            ST_IDLE:
                if (cmd_valid)
                begin
                    case (cmd.op)
                        OP_PUT:
                            state_next = put_wrap ? ST_SWEEP : ST_STATUS;
                        OP_TYPE:
                            state_next = (lc_reg != LINE_FULL && put_wrap) ? ST_SWEEP : ST_STATUS;
                        OP_NEWROW:
                            state_next = nr_wrap ? ST_SWEEP : ST_STATUS;
                        OP_NEWROW_IF:
                            state_next = (col_reg != '0 && nr_wrap) ? ST_SWEEP : ST_STATUS;
                        OP_DELIVER:
                            if (readers_reg != '0)
                                state_next = nr_wrap ? ST_SWEEP : ST_LINE_RD;
                            else
                                state_next = ST_STATUS;
                        OP_ESCAPE:   state_next = ST_SWEEP;
                        OP_CLEAR:    state_next = ST_SWEEP;
                        OP_READ:     state_next = ST_READ_WAIT;
                        default:     state_next = ST_STATUS;
                    endcase
                end
            ST_READ_WAIT:
                state_next = ST_STATUS;
            ST_STATUS:
                if (slot_free)
                    state_next = ST_IDLE;
            ST_LINE_RD:
                state_next = (line_idx_reg == n_reg) ? ST_TERM : ST_LINE_EMIT;
            ST_LINE_EMIT:
                if (slot_free)
                    state_next = ST_LINE_RD;
            ST_TERM:
                if (slot_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Datapath and outputs.
    always_comb
    begin
        ret_next         = ret_reg;
        cursor_next      = cursor_reg;
        col_next         = col_reg;
        lc_next          = lc_reg;
        readers_next     = readers_reg;
        scan_next        = scan_reg;
        sweep_blank_next = sweep_blank_reg;
        wr_pend_next     = 1'b0;
        wr_addr_next     = wr_addr_reg;
        wr_use_rd_next   = 1'b0;
        wr_data_next     = wr_data_reg;
        rd_addr          = '0;
        read_ok_next     = read_ok_reg;
        cchar_next       = cchar_reg;
        ccol_next        = ccol_reg;
        n_next           = n_reg;
        line_idx_next    = line_idx_reg;
        line_we          = 1'b0;
        cmd_pop          = 1'b0;
        out_valid_next   = out_valid_reg && !out_ready;
        out_item_next    = out_item_reg;

        case (state_reg)
            ST_SWEEP:
            begin
                wr_pend_next   = 1'b1;
                wr_addr_next   = scan_reg;
                wr_data_next   = BLANK;
                wr_use_rd_next = !sweep_blank_reg && (scan_reg < LAST_ROW);
                rd_addr        = scan_ahead[CURSOR_W-1:0];
                scan_next      = scan_reg + 1'b1;
            end
            ST_IDLE:
                if (cmd_valid)
                begin
                    cmd_pop          = 1'b1;
                    cchar_next       = '0;
                    ccol_next        = '0;
                    scan_next        = '0;
                    sweep_blank_next = 1'b0;
                    ret_next         = ST_STATUS;
                    case (cmd.op)
                        OP_PUT:
                        begin
                            wr_pend_next = 1'b1;
                            wr_addr_next = cursor_reg;
                            wr_data_next = cmd.character;
                            cursor_next  = put_cursor;
                            col_next     = put_col;
                        end
                        OP_TYPE:
                            if (lc_reg != LINE_FULL)
                            begin
                                line_we      = 1'b1;
                                lc_next      = lc_reg + 1'b1;
                                wr_pend_next = 1'b1;
                                wr_addr_next = cursor_reg;
                                wr_data_next = cmd.character;
                                cursor_next  = put_cursor;
                                col_next     = put_col;
                            end
                        OP_NEWROW:
                        begin
                            cursor_next = nr_cursor;
                            col_next    = '0;
                        end
                        OP_NEWROW_IF:
                            if (col_reg != '0)
                            begin
                                cursor_next = nr_cursor;
                                col_next    = '0;
                            end
                        OP_BACKSPACE:
                            if (lc_reg != '0)
                            begin
                                lc_next      = lc_reg - 1'b1;
                                wr_pend_next = 1'b1;
                                wr_data_next = BLANK;
                                if (cursor_reg != '0)
                                begin
                                    cursor_next  = cursor_reg - 1'b1;
                                    wr_addr_next = cursor_reg - 1'b1;
                                    col_next     = (col_reg == '0) ? LAST_COL : col_reg - 1'b1;
                                end
                                else
                                    wr_addr_next = '0;
                            end
                        OP_DELIVER:
                            if (readers_reg != '0)
                            begin
                                readers_next  = readers_reg - 1'b1;
                                n_next        = lc_reg;
                                lc_next       = '0;
                                cursor_next   = nr_cursor;
                                col_next      = '0;
                                line_idx_next = '0;
                                ret_next      = ST_LINE_RD;
                            end
                        OP_ESCAPE:
                        begin
                            lc_next          = '0;
                            cursor_next      = '0;
                            col_next         = '0;
                            sweep_blank_next = 1'b1;
                        end
                        OP_CLEAR:
                        begin
                            cursor_next      = '0;
                            col_next         = '0;
                            sweep_blank_next = 1'b1;
                        end
                        OP_READ:
                        begin
                            rd_addr      = cmd.cell_index;
                            read_ok_next = (cmd.cell_index < CURSOR_W'(CELLS));
                        end
                        OP_READER_REQ:
                            if (readers_reg != READER_MAX)
                                readers_next = readers_reg + 1'b1;
                        default:
                            cmd_pop = 1'b1;
                    endcase
                end
            ST_READ_WAIT:
            begin
                cchar_next = read_ok_reg ? rd_data_reg : '0;
                ccol_next  = read_ok_reg ? screen_color : '0;
            end
            ST_STATUS:
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_item_next  = '{result_kind: 1'b0, cursor_position: cursor_reg,
                                      line_length: lc_reg, cell_char: cchar_reg,
                                      cell_color: ccol_reg, line_char: 8'd0, last: 1'b1,
                                      readers_pending: readers_reg};
                end
            ST_LINE_EMIT:
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_item_next  = '{result_kind: 1'b1, cursor_position: cursor_reg,
                                      line_length: lc_reg, cell_char: 8'd0,
                                      cell_color: 8'd0, line_char: line_rd_reg, last: 1'b0,
                                      readers_pending: readers_reg};
                    line_idx_next  = line_idx_reg + 1'b1;
                end
            ST_TERM:
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_item_next  = '{result_kind: 1'b1, cursor_position: cursor_reg,
                                      line_length: lc_reg, cell_char: 8'd0,
                                      cell_color: 8'd0, line_char: 8'd0, last: 1'b1,
                                      readers_pending: readers_reg};
                end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_SWEEP;
            ret_reg         <= ST_IDLE;
            cursor_reg      <= '0;
            col_reg         <= '0;
            lc_reg          <= '0;
            readers_reg     <= '0;
            scan_reg        <= '0;
            sweep_blank_reg <= 1'b1;
            wr_pend_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            ret_reg         <= ret_next;
            cursor_reg      <= cursor_next;
            col_reg         <= col_next;
            lc_reg          <= lc_next;
            readers_reg     <= readers_next;
            scan_reg        <= scan_next;
            sweep_blank_reg <= sweep_blank_next;
            wr_pend_reg     <= wr_pend_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wr_addr_reg   <= wr_addr_next;
        wr_use_rd_reg <= wr_use_rd_next;
        wr_data_reg   <= wr_data_next;
        read_ok_reg   <= read_ok_next;
        cchar_reg     <= cchar_next;
        ccol_reg      <= ccol_next;
        n_reg         <= n_next;
        line_idx_reg  <= line_idx_next;
        out_item_reg  <= out_item_next;
    end

    // Screen memory: one registered read port, one write port fed by the write stage.
    always_ff @(posedge clk)
    begin
        if (wr_pend_reg)
            frame_mem[wr_addr_reg] <= wr_use_rd_reg ? rd_data_reg : wr_data_reg;
        rd_data_reg <= frame_mem[rd_addr];
    end

    // Edit line memory.
    always_ff @(posedge clk)
    begin
        if (line_we)
            line_mem[lc_reg] <= cmd.character;
        line_rd_reg <= line_mem[line_idx_reg];
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    `TCLE_ASSERT_NEVER(a_cursor_on_screen, cursor_reg >= CURSOR_W'(CELLS), "cursor off screen")
    `TCLE_ASSERT_NEVER(a_col_range, col_reg > LAST_COL, "column out of range")
    `TCLE_ASSERT_NEVER(a_line_range, lc_reg > LINE_FULL, "edit line overfull")
    `TCLE_ASSERT_IMPLY(a_copy_from_sweep, wr_pend_reg && wr_use_rd_reg, $past(state_reg) == ST_SWEEP, "row copy outside sweep")

endmodule

FILE: bench/console_checker.sv
// Checker that predicts and compares the console results.
`timescale 1ns / 100ps

module console_checker
    import tcle_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_ready,
    input  in_item_t   in_item,
    input  logic       out_valid,
    input  logic       out_ready,
    input  out_item_t  out_item,
    input  logic       cfg_valid,
    input  logic       cfg_ready,
    input  logic [7:0] cfg_data,
    output int         errors,
    output int         pending,
    output int         delivered
);

    logic [7:0] color_q;
    logic [7:0] chars_q [CELLS];
    int         cur_q;
    logic [7:0] line_q [LINE_DEPTH];
    int         len_q;
    int         readers_q;
    out_item_t  due_q [$];

    task automatic report(input string what, input int got, input int want);
        errors++;
        $display("mismatch %s: got %0d expected %0d", what, got, want);
    endtask

    task automatic scroll_if_end();
        if (cur_q >= CELLS) begin
            for (int i = 0; i < CELLS - COLUMNS; i++) chars_q[i] = chars_q[i + COLUMNS];
            for (int i = CELLS - COLUMNS; i < CELLS; i++) chars_q[i] = BLANK;
            cur_q = cur_q - COLUMNS;
        end
    endtask

    task automatic put_char(input logic [7:0] ch);
        chars_q[cur_q] = ch;
        cur_q++;
        scroll_if_end();
    endtask

    task automatic next_row();
        cur_q = cur_q + COLUMNS - cur_q % COLUMNS;
        scroll_if_end();
    endtask

    task automatic blank_screen();
        for (int i = 0; i < CELLS; i++) chars_q[i] = BLANK;
        cur_q = 0;
    endtask

    function automatic out_item_t status(input logic rk, input logic [7:0] cc,
                                         input logic [7:0] col, input logic [7:0] lc,
                                         input logic lst);
        out_item_t r;
        r.result_kind     = rk;
        r.cursor_position = CURSOR_W'(cur_q);
        r.line_length     = LINE_W'(len_q);
        r.cell_char       = cc;
        r.cell_color      = col;
        r.line_char       = lc;
        r.last            = lst;
        r.readers_pending = READER_W'(readers_q);
        return r;
    endfunction

    // Applies one request to the shadow console and queues its results.
    task automatic predict(input in_item_t it);
        logic [7:0] cc;
        logic [7:0] col;
        int         n;
        cc  = 8'd0;
        col = 8'd0;
        case (it.kind)
            KIND_PRINT:
                if (it.character == KEY_NEWLINE) next_row();
                else if (it.character != 8'd0) put_char(it.character);
            KIND_TYPED:
                if (it.character == KEY_BACKSPACE) begin
                    if (len_q != 0) begin
                        len_q--;
                        if (cur_q > 0) cur_q--;
                        chars_q[cur_q] = BLANK;
                    end
                end else if (it.character == KEY_NEWLINE) begin
                    if (readers_q != 0) begin
                        n = len_q;
                        readers_q--;
                        len_q = 0;
                        next_row();
                        for (int i = 0; i < n; i++)
                            due_q.push_back(status(1'b1, 8'd0, 8'd0, line_q[i], 1'b0));
                        due_q.push_back(status(1'b1, 8'd0, 8'd0, 8'd0, 1'b1));
                        delivered++;
                        return;
                    end
                end else if (it.character == KEY_ESCAPE) begin
                    len_q = 0;
                    blank_screen();
                end else if (len_q < LINE_DEPTH) begin
                    line_q[len_q] = it.character;
                    len_q++;
                    put_char(it.character);
                end
            KIND_NEWLINE:
                if (cur_q % COLUMNS != 0) next_row();
            KIND_CLEAR:
                blank_screen();
            KIND_READ:
                if (it.cell_index < CELLS) begin
                    cc  = chars_q[it.cell_index];
                    col = color_q;
                end
            KIND_READER:
                if (readers_q < READER_DEPTH) readers_q++;
            default: ;
        endcase
        due_q.push_back(status(1'b0, cc, col, 8'd0, 1'b1));
    endtask

    always @(posedge clk or negedge rst_n) begin
        out_item_t w;
        if (!rst_n) begin
            color_q   <= COLOR_RESET;
            for (int i = 0; i < CELLS; i++) chars_q[i] = BLANK;
            cur_q     = 0;
            len_q     = 0;
            readers_q = 0;
            due_q.delete();
            errors    = 0;
            delivered = 0;
        end else begin
            if (out_valid && out_ready) begin
                if (due_q.size() == 0) begin
                    errors++;
                    $display("unexpected result with nothing outstanding");
                end else begin
                    w = due_q.pop_front();
                    if (out_item.result_kind != w.result_kind)
                        report("result_kind", out_item.result_kind, w.result_kind);
                    if (out_item.cursor_position != w.cursor_position)
                        report("cursor_position", out_item.cursor_position,
                               w.cursor_position);
                    if (out_item.line_length != w.line_length)
                        report("line_length", out_item.line_length, w.line_length);
                    if (out_item.cell_char != w.cell_char)
                        report("cell_char", out_item.cell_char, w.cell_char);
                    if (out_item.cell_color != w.cell_color)
                        report("cell_color", out_item.cell_color, w.cell_color);
                    if (out_item.line_char != w.line_char)
                        report("line_char", out_item.line_char, w.line_char);
                    if (out_item.last != w.last)
                        report("last", out_item.last, w.last);
                    if (out_item.readers_pending != w.readers_pending)
                        report("readers_pending", out_item.readers_pending,
                               w.readers_pending);
                end
            end
            if (in_valid && in_ready) predict(in_item);
            if (cfg_valid && cfg_ready) color_q <= cfg_data;
        end
    end

    assign pending = due_q.size();

endmodule

FILE: bench/tb.sv
// Testbench top: drives console requests and gives the verdict.
`timescale 1ns / 100ps

module tb;
    import tcle_pkg::*;

    localparam int RANDOM_ITEMS = 160;
    // Cycles with no accepted request or result before the run is declared hung.
    // A scroll or clear walks the whole screen, and the queue holds four of them.
    localparam int STALL_LIMIT = 40000;
    // Settle time after the last result: one full screen walk and margin.
    localparam int TAIL_CYCLES = 2100;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    in_item_t   in_item;
    logic       out_valid;
    logic       out_ready;
    out_item_t  out_item;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [7:0] cfg_data;
    int         errors;
    int         pending;
    int         delivered;
    int         sent;
    int         quiet;
    // The receiver reads these to decide how it idles.
    bit         hold_off;
    bit         calm;

    text_console_line_editor_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    console_checker u_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending),
        .delivered (delivered)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Sends one request, with a random idle gap first unless calm is set.
    // Valid stays high after acceptance until an idle gap or a drain drops it.
    task automatic send(input logic [2:0] kind, input logic [7:0] ch,
                        input logic [10:0] idx);
        while (!calm && $urandom_range(99) < 11) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid             <= 1'b1;
        in_item.kind         <= kind;
        in_item.character    <= ch;
        in_item.cell_index   <= idx;
        do @(posedge clk); while (!in_ready);
        sent++;
    endtask

    // Waits until every predicted result has come, then lets the block settle.
    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    // Writes the color register while the block is idle.
    task automatic set_color(input logic [7:0] value);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Picks a typed key, mostly printable, sometimes an editing key.
    function automatic logic [7:0] pick_key();
        int r;
        r = $urandom_range(99);
        if (r < 8) return KEY_BACKSPACE;
        if (r < 14) return KEY_NEWLINE;
        if (r < 16) return KEY_ESCAPE;
        if (r < 22) return 8'($urandom);
        return 8'($urandom_range(8'h21, 8'h7E));
    endfunction

    // One random request: a mix weighted toward typing and printing.
    task automatic random_request();
        int         r;
        logic [7:0] ch;
        r = $urandom_range(99);
        if (r < 35) send(KIND_TYPED, pick_key(), 11'($urandom));
        else if (r < 62) begin
            ch = ($urandom_range(9) == 0) ? KEY_NEWLINE : 8'($urandom);
            send(KIND_PRINT, ch, 11'($urandom));
        end else if (r < 68) send(KIND_NEWLINE, 8'($urandom), 11'($urandom));
        else if (r < 69) send(KIND_CLEAR, 8'($urandom), 11'($urandom));
        else if (r < 84) begin
            if ($urandom_range(9) == 0) send(KIND_READ, 8'($urandom), 11'($urandom));
            else send(KIND_READ, 8'($urandom), 11'($urandom_range(CELLS - 1)));
        end else if (r < 96) send(KIND_READER, 8'($urandom), 11'($urandom));
        else send(3'($urandom_range(6, 7)), 8'($urandom), 11'($urandom));
    endtask

    // The receiver idles at random, except during a calm stretch, and holds
    // off completely while hold_off is set.
    initial begin
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (hold_off) out_ready <= 1'b0;
            else out_ready <= calm || ($urandom_range(99) >= 11);
        end
    end

    // Watchdog on progress.
    initial begin
        quiet = 0;
        forever begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
            else quiet++;
            if (quiet >= STALL_LIMIT) begin
                $display("tb: errors");
                $finish;
            end
        end
    end

    initial begin
        in_valid  <= 1'b0;
        in_item   <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= 8'd0;
        hold_off  = 1'b0;
        calm      = 1'b0;
        sent      = 0;
        rst_n     <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: edge values of every field and the special cases.
        send(KIND_READ, 8'd0, 11'd0);              // reset color shows on a read
        send(KIND_PRINT, 8'd0, 11'd0);             // print of zero does nothing
        send(KIND_TYPED, KEY_BACKSPACE, 11'd0);    // backspace on an empty line
        send(KIND_TYPED, KEY_NEWLINE, 11'd0);      // newline with nobody waiting
        send(KIND_TYPED, 8'hFF, 11'h7FF);          // echoed at cell zero
        send(KIND_NEWLINE, 8'd0, 11'd0);           // moves to the next row
        send(KIND_NEWLINE, 8'd0, 11'd0);           // already at a row start
        send(KIND_CLEAR, 8'd0, 11'd0);             // line kept, cursor to zero
        send(KIND_TYPED, KEY_BACKSPACE, 11'd0);    // backspace at cell zero
        send(KIND_PRINT, 8'h41, 11'd0);
        send(KIND_READ, 8'd0, 11'(CELLS - 1));
        send(KIND_READ, 8'd0, 11'(CELLS));         // beyond the screen
        send(KIND_READ, 8'd0, 11'h7FF);
        send(KIND_READER, 8'd0, 11'd0);
        send(KIND_TYPED, 8'h7A, 11'd0);
        send(KIND_TYPED, KEY_NEWLINE, 11'd0);      // delivers one character
        send(KIND_TYPED, KEY_ESCAPE, 11'd0);
        send(3'd6, 8'hAA, 11'h555);
        send(3'd7, 8'h55, 11'h2AA);
        set_color(8'd0);
        send(KIND_READ, 8'd0, 11'd5);
        set_color(8'hFF);
        send(KIND_READ, 8'd0, 11'd5);

        // Saturate the reader count, fill the line past its depth and deliver.
        for (int i = 0; i < READER_DEPTH + 1; i++) send(KIND_READER, 8'd0, 11'd0);
        for (int i = 0; i < LINE_DEPTH + 2; i++)
            send(KIND_TYPED, 8'($urandom_range(8'h21, 8'hFF)), 11'd0);
        send(KIND_TYPED, KEY_NEWLINE, 11'd0);

        // Print past the screen end so the screen scrolls a few times.
        for (int i = 0; i < 30; i++) send(KIND_PRINT, KEY_NEWLINE, 11'd0);
        send(KIND_READ, 8'd0, 11'd0);

        // The receiver stalls long enough for the command queue to fill.
        hold_off = 1'b1;
        fork
            begin
                repeat (400) @(posedge clk);
                hold_off = 1'b0;
            end
            for (int i = 0; i < 12; i++) send(KIND_READ, 8'($urandom), 11'($urandom));
        join

        // Random part across several color settings, with a calm stretch.
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == 60) set_color(8'($urandom));
            if (i == 120) set_color(COLOR_RESET);
            calm = (i >= 70 && i < 110);
            random_request();
        end
        calm = 1'b0;

        drain();
        $display("tb: sent %0d requests, %0d lines delivered, several colors and scrolls",
                 sent, delivered);
        if (errors == 0) $display("tb: clean");
        else $display("tb: errors");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/tcle_pkg.sv
hw/rtl/tcle_front.sv
hw/rtl/tcle_cmd_queue.sv
hw/rtl/tcle_back.sv
hw/rtl/text_console_line_editor_core.sv
bench/console_checker.sv
bench/tb.sv
